// ----- sv/sfwp_pkg.sv -----
`timescale 1ns / 1ps

package sfwp_pkg;

    // Frame layout
    localparam int FRAME_BYTES     = 19;
    localparam int WEIGHT_CHARS    = 9;
    localparam int FRACTION_DIGITS = 3;
    localparam int SYMBOL_OFFSET   = 3;
    localparam int WEIGHT_OFFSET   = 4;
    localparam int WEIGHT_END      = WEIGHT_OFFSET + WEIGHT_CHARS;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 5;
    localparam int MAG_W   = 40;
    localparam int FRAC_W  = 2;
    localparam int SCALE_W = 10;
    localparam int OUT_W   = MAG_W + 1;

    // Characters
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'd32;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'd9;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'd13;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'd43;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'd45;
    localparam logic [BYTE_W-1:0] CH_POINT  = 8'd46;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'd48;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'd57;
    localparam logic [BYTE_W-1:0] HEADER_RST = 8'd69;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [MAG_W-1:0]  t_mag;
    typedef logic signed [OUT_W-1:0] t_weight;

    // Power of ten that brings the kept fraction digits up to thousandths
    function automatic logic [SCALE_W-1:0] frac_scale(input logic [FRAC_W-1:0] frac);
        logic [SCALE_W-1:0] s;
        case (frac)
            2'd0:    s = 10'd1000;
            2'd1:    s = 10'd100;
            2'd2:    s = 10'd10;
            default: s = 10'd1;
        endcase
        return s;
    endfunction

endpackage

// ----- sv/sfwp_rx_if.sv -----
`timescale 1ns / 1ps

interface sfwp_rx_if;
    import sfwp_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- sv/sfwp_res_if.sv -----
`timescale 1ns / 1ps

interface sfwp_res_if;
    import sfwp_pkg::*;

    logic    valid;
    logic    ready;
    t_weight weight_milli;
    logic    parse_ok;

    modport source (output valid, output weight_milli, output parse_ok, input ready);
    modport sink   (input valid, input weight_milli, input parse_ok, output ready);
endinterface

// ----- sv/scale_frame_weight_parser.sv -----
`timescale 1ns / 1ps

// Channel   | Dir | Word                                 | Handshake
// ----------+-----+--------------------------------------+-------------
// i_rx      | in  | rx_byte[7:0]                         | valid/ready
// o_res     | out | weight_milli[40:0] (s), parse_ok     | valid/ready
// i_cfg_*   | in  | header byte [7:0]                    | write enable
//
// One byte per cycle sustained while the snapshot stage can take frame ends.
// A byte is held in the input register once taken and parsed from there; a
// frame's word passes snapshot, scale (40x10 multiply) and sign stages to o_res.
// Synchronous active-low reset clears frame position, parse state, all stage
// valids and sets the header byte to 'E'.
// Each stage has its own valid; a waiting result stalls only the stages behind
// it that are full, so bytes keep flowing between frames.

module scale_frame_weight_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [sfwp_pkg::BYTE_W-1:0] i_cfg_wr_data,
    sfwp_rx_if.sink                     i_rx,
    sfwp_res_if.source                  o_res
);
    import sfwp_pkg::*;

    // Parse phases
    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_INT   = 2'd1;
    localparam logic [1:0] PH_FRAC  = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    localparam logic [POS_W-1:0] POS_SYMBOL = POS_W'(SYMBOL_OFFSET);
    localparam logic [POS_W:0]   POS_WBEG   = (POS_W+1)'(WEIGHT_OFFSET);
    localparam logic [POS_W:0]   POS_WEND   = (POS_W+1)'(WEIGHT_END);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);
    localparam logic [FRAC_W-1:0] FRAC_MAX  = FRAC_W'(FRACTION_DIGITS);
    localparam int MUL_W = MAG_W + SCALE_W;

    // Config register
    t_byte r_header;

    // Input register
    logic  r_in_valid;
    t_byte r_in_byte;

    // Parse state
    logic [POS_W-1:0]  r_pos,   n_pos;
    t_mag              r_mag,   n_mag;
    logic [FRAC_W-1:0] r_frac,  n_frac;
    logic [1:0]        r_phase, n_phase;
    logic              r_seen,  n_seen;
    logic              r_fneg,  n_fneg;
    logic              r_sneg,  n_sneg;

    // Snapshot stage
    logic              r_s1_valid;
    t_mag              r_s1_mag;
    logic [FRAC_W-1:0] r_s1_frac;
    logic              r_s1_seen;
    logic              r_s1_neg;

    // Scaled stage
    logic r_s2_valid;
    t_mag r_s2_mag;
    logic r_s2_seen;
    logic r_s2_neg;

    // Output register
    logic    r_out_valid;
    t_weight r_out_weight;
    logic    r_out_ok;

    logic frame_end;
    logic step;
    logic s1_free, s2_free, out_free;
    logic s1_go, s2_go;
    logic [MUL_W-1:0] mul_prod;
    t_mag scaled_mag;
    logic [OUT_W-1:0] mag_ext;

    // Stage hand-off
    assign out_free  = !r_out_valid || o_res.ready;
    assign s2_go     = r_s2_valid && out_free;
    assign s2_free   = !r_s2_valid || out_free;
    assign s1_go     = r_s1_valid && s2_free;
    assign s1_free   = !r_s1_valid || s2_free;
    assign step      = r_in_valid && (!frame_end || s1_free);
    assign i_rx.ready = !r_in_valid || step;

    // Byte parse, one step per byte
    always_comb begin
        logic [POS_W-1:0]  pos;
        logic              c_digit;
        logic              c_space;
        logic              add;
        logic [3:0]        d;
        logic [MAG_W+3:0]  x10;

        pos = (r_in_byte == r_header) ? '0 : r_pos;

        n_mag   = r_mag;
        n_frac  = r_frac;
        n_phase = r_phase;
        n_seen  = r_seen;
        n_fneg  = r_fneg;
        n_sneg  = r_sneg;
        if (pos == '0) begin
            n_mag   = '0;
            n_frac  = '0;
            n_phase = PH_SPACE;
            n_seen  = 1'b0;
            n_fneg  = 1'b0;
            n_sneg  = 1'b0;
        end

        c_digit = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
        c_space = (r_in_byte == CH_SPACE) || ((r_in_byte >= CH_TAB) && (r_in_byte <= CH_CR));
        d       = 4'(r_in_byte - CH_ZERO);
        add     = 1'b0;

        if (pos == POS_SYMBOL) begin
            n_sneg = (r_in_byte == CH_MINUS);
        end else if ({1'b0, pos} >= POS_WBEG && {1'b0, pos} < POS_WEND) begin
            case (n_phase)
                PH_SPACE: begin
                    if (c_space) begin
                        n_phase = PH_SPACE;
                    end else if (r_in_byte == CH_PLUS || r_in_byte == CH_MINUS) begin
                        n_fneg  = (r_in_byte == CH_MINUS);
                        n_phase = PH_INT;
                    end else if (c_digit) begin
                        add     = 1'b1;
                        n_phase = PH_INT;
                    end else if (r_in_byte == CH_POINT) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
                PH_INT: begin
                    if (c_digit) begin
                        add = 1'b1;
                    end else if (r_in_byte == CH_POINT) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
                PH_FRAC: begin
                    if (c_digit) begin
                        n_seen = 1'b1;
                        if (n_frac < FRAC_MAX) begin
                            add    = 1'b1;
                            n_frac = n_frac + 1'b1;
                        end
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
                default: begin
                    n_phase = PH_STOP;
                end
            endcase
        end

        // mag*10 + d, saturating at full scale
        x10 = {n_mag, 3'b000} + {2'b00, n_mag, 1'b0} + (MAG_W+4)'(d);
        if (add) begin
            n_seen = 1'b1;
            n_mag  = (x10[MAG_W+3:MAG_W] != '0) ? '1 : x10[MAG_W-1:0];
        end

        frame_end = (pos == POS_LAST);
        n_pos     = frame_end ? '0 : pos + 1'b1;
    end

    // Scale to thousandths, saturating
    assign mul_prod   = MUL_W'(r_s1_mag) * MUL_W'(frac_scale(r_s1_frac));
    assign scaled_mag = (mul_prod[MUL_W-1:MAG_W] != '0) ? '1 : mul_prod[MAG_W-1:0];
    assign mag_ext    = {1'b0, r_s2_mag};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header    <= HEADER_RST;
            r_in_valid  <= 1'b0;
            r_pos       <= '0;
            r_mag       <= '0;
            r_frac      <= '0;
            r_phase     <= PH_SPACE;
            r_seen      <= 1'b0;
            r_fneg      <= 1'b0;
            r_sneg      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_header <= i_cfg_wr_data;
            end
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (step) begin
                r_pos   <= n_pos;
                r_mag   <= n_mag;
                r_frac  <= n_frac;
                r_phase <= n_phase;
                r_seen  <= n_seen;
                r_fneg  <= n_fneg;
                r_sneg  <= n_sneg;
            end
            if (s1_free) begin
                r_s1_valid <= step && frame_end;
            end
            if (s2_free) begin
                r_s2_valid <= s1_go;
            end
            if (out_free) begin
                r_out_valid <= s2_go;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (step && frame_end && s1_free) begin
            r_s1_mag  <= n_mag;
            r_s1_frac <= n_frac;
            r_s1_seen <= n_seen;
            r_s1_neg  <= n_fneg ^ n_sneg;
        end
        if (s1_go) begin
            r_s2_mag  <= scaled_mag;
            r_s2_seen <= r_s1_seen;
            r_s2_neg  <= r_s1_neg;
        end
        if (s2_go) begin
            r_out_ok <= r_s2_seen;
            if (!r_s2_seen) begin
                r_out_weight <= '0;
            end else if (r_s2_neg) begin
                r_out_weight <= t_weight'(-mag_ext);
            end else begin
                r_out_weight <= t_weight'(mag_ext);
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.weight_milli = r_out_weight;
    assign o_res.parse_ok     = r_out_ok;

    // Checks
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("frame position beyond frame");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ok |-> r_out_weight == '0)
        else $error("failed parse gave a non-zero weight");

    a_frame_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && frame_end |=> r_s1_valid)
        else $error("frame end lost before scale stage");

    a_no_parse_pos0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && frame_end |=> r_pos == '0)
        else $error("position not restarted after frame end");

endmodule
